// ===== rtl/lrgd_pkg.sv =====
// shared types and constants for the gradient descent trainer
`timescale 1ns / 1ps
`default_nettype none
package lrgd_pkg;
    localparam int MAX_SAMPLES  = 64;
    localparam int MAX_FEATURES = 8;
    localparam logic signed [31:0] INIT_WEIGHT0 = 32'sd150733;
    localparam logic [15:0] RESET_RATE = 16'd6554;

    typedef enum logic [1:0] {
        CMD_FEATURE = 2'd0,
        CMD_TARGET  = 2'd1,
        CMD_TRAIN   = 2'd2,
        CMD_WEIGHT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_RATE  = 2'd0,
        REG_ITER  = 2'd1,
        REG_SAMP  = 2'd2,
        REG_FEAT  = 2'd3
    } reg_idx_t;

    // saturate a 64 bit value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh000000007fffffff;
        lo = -64'sh0000000080000000;
        if (x > hi)
            return 32'sh7fffffff;
        else if (x < lo)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/linear_regression_gradient_descent_top.sv =====
// top level of the batch gradient descent linear regression trainer
//
// channel   signals                                         direction
// command   start busy command sample_index feature_index value   in (busy out)
// config    cfg_valid cfg_ready cfg_index cfg_data          in (cfg_ready out)
// result    weight_valid weight_index weight last           out
//
// loads are accepted, then written to memory. one 32x32 multiplier is
// shared by every product of a train iteration, the step included, and a
// restoring divider retires one quotient bit a cycle (64 per weight).
// Weights then stream one a cycle.
// Reset restores the registers and initial weights; config waits while
// busy, and the receiver cannot stall, so results leave on their strobe.
`timescale 1ns / 1ps
`default_nettype none
module linear_regression_gradient_descent_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [5:0]  sample_index,
    input  wire logic [2:0]  feature_index,
    input  wire logic signed [31:0] value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             weight_valid,
    output logic [2:0]       weight_index,
    output logic signed [31:0] weight,
    output logic             last
);
    import lrgd_pkg::*;

    localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int FLIM = (MAX_FEATURES < 8) ? MAX_FEATURES : 8;
    localparam int MDEPTH = MAX_SAMPLES * MAX_FEATURES;
    localparam int AW = SW + FW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_ITER, ST_PRED, ST_PMUL, ST_ERR, ST_GMUL, ST_GACC,
        ST_DIV, ST_STEP, ST_STEPH, ST_UPD, ST_COPY, ST_EMIT
    } state_t;

    state_t state_reg;
    logic [15:0] rate_reg, iter_reg;
    logic [6:0]  samp_reg;
    logic [3:0]  feat_reg;
    logic [1:0]  cmd_reg;
    logic [5:0]  si_reg;
    logic [2:0]  fi_reg;
    logic signed [31:0] val_reg;

    logic signed [31:0] xmem [MDEPTH];
    logic signed [31:0] tmem [MAX_SAMPLES];
    logic signed [31:0] w_reg [MAX_FEATURES];
    logic signed [31:0] nw_reg [MAX_FEATURES];
    logic signed [31:0] xrd_reg, trd_reg;

    logic [15:0] it_reg;
    logic [3:0]  f_reg, i_reg, nf_reg;
    logic [6:0]  s_reg, ns_reg;
    logic signed [63:0] acc_reg, gsum_reg, prod_reg;
    logic signed [31:0] err_reg;
    logic [6:0] dcnt_reg;
    logic [63:0] quo_reg, rem_reg;
    logic        neg_reg;
    logic [2:0]  ecnt_reg;

    // clamped counts from registers
    logic [6:0] ns_c;
    logic [3:0] nf_c;
    always_comb
    begin
        ns_c = (samp_reg == 7'd0) ? 7'd1 : samp_reg;
        if (32'(ns_c) > MAX_SAMPLES) ns_c = 7'(MAX_SAMPLES);
        nf_c = (feat_reg == 4'd0) ? 4'd1 : feat_reg;
        if (32'(nf_c) > FLIM) nf_c = 4'(FLIM);
    end

    // shared multiplier operands; the step uses it twice on 31 bit slices of the mean
    logic signed [31:0] ma, mb;
    logic signed [63:0] mp;
    always_comb
    begin
        ma = err_reg;
        mb = xrd_reg;
        if (state_reg == ST_PMUL)
            ma = w_reg[i_reg[FW-1:0]];
        else if (state_reg == ST_STEP)
        begin
            ma = {1'b0, quo_reg[30:0]};
            mb = {16'd0, rate_reg};
        end
        else if (state_reg == ST_STEPH)
        begin
            ma = {1'b0, quo_reg[61:31]};
            mb = {16'd0, rate_reg};
        end
        mp = 64'(ma) * 64'(mb);
    end

    // memory read address
    logic [3:0] col;
    assign col = (state_reg == ST_PRED || state_reg == ST_PMUL) ? i_reg : f_reg;
    logic [AW-1:0] raddr;
    assign raddr = AW'({s_reg[SW-1:0], col[FW-1:0]});

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && cmd_reg == CMD_FEATURE &&
            32'(si_reg) < MAX_SAMPLES && 32'(fi_reg) < MAX_FEATURES)
            xmem[AW'({si_reg[SW-1:0], fi_reg[FW-1:0]})] <= val_reg;
        if (state_reg == ST_LOAD && cmd_reg == CMD_TARGET && 32'(si_reg) < MAX_SAMPLES)
            tmem[si_reg[SW-1:0]] <= val_reg;
        xrd_reg <= xmem[raddr];
        trd_reg <= tmem[s_reg[SW-1:0]];
    end

    logic signed [63:0] fl;
    logic signed [63:0] smag;
    logic signed [63:0] stepv;
    logic [63:0] rsh;
    assign fl = prod_reg >>> 16;
    assign rsh = {rem_reg[62:0], quo_reg[63]};
    // magnitude of mean times rate, then signed floor shift
    assign smag = prod_reg + (mp <<< 31);
    assign stepv = (neg_reg ? -smag : smag) >>> 16;

    assign busy = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rate_reg <= RESET_RATE;
            iter_reg <= 16'd1;
            samp_reg <= 7'd1;
            feat_reg <= 4'd1;
            for (int k = 0; k < MAX_FEATURES; k++)
            begin
                w_reg[k] <= (k == 0) ? INIT_WEIGHT0 : 32'sd0;
                nw_reg[k] <= 32'sd0;
            end
            weight_valid <= 1'b0;
            ecnt_reg <= 3'd0;
        end
        else
        begin
            weight_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_RATE: rate_reg <= cfg_data;
                    REG_ITER: iter_reg <= cfg_data;
                    REG_SAMP: samp_reg <= cfg_data[6:0];
                    REG_FEAT: feat_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                if (start)
                begin
                    cmd_reg <= command; si_reg <= sample_index;
                    fi_reg <= feature_index; val_reg <= value;
                    ns_reg <= ns_c; nf_reg <= nf_c;
                    it_reg <= 16'd0;
                    state_reg <= (command == CMD_TRAIN) ? ST_ITER : ST_LOAD;
                end
                ST_LOAD:
                begin
                    if (cmd_reg == CMD_WEIGHT && 32'(fi_reg) < MAX_FEATURES)
                        w_reg[fi_reg[FW-1:0]] <= val_reg;
                    state_reg <= ST_IDLE;
                end
                ST_ITER:
                begin
                    f_reg <= 4'd0; s_reg <= 7'd0; i_reg <= 4'd0;
                    acc_reg <= 64'sd0; gsum_reg <= 64'sd0;
                    if (it_reg == iter_reg)
                    begin
                        ecnt_reg <= 3'd0;
                        state_reg <= ST_EMIT;
                    end
                    else
                        state_reg <= ST_PRED;
                end
                // address issued, wait read
                ST_PRED: state_reg <= ST_PMUL;
                ST_PMUL:
                begin
                    prod_reg <= mp;
                    if (i_reg != 4'd0) acc_reg <= acc_reg + fl;
                    if (i_reg + 4'd1 == nf_reg)
                        state_reg <= ST_ERR;
                    else
                    begin
                        i_reg <= i_reg + 4'd1;
                        state_reg <= ST_PRED;
                    end
                end
                ST_ERR:
                begin
                    err_reg <= sat32(64'(sat32(acc_reg + fl)) - 64'(trd_reg));
                    state_reg <= ST_GMUL;
                end
                ST_GMUL:
                begin
                    prod_reg <= mp;
                    state_reg <= ST_GACC;
                end
                ST_GACC:
                begin
                    gsum_reg <= gsum_reg + fl;
                    acc_reg <= 64'sd0; i_reg <= 4'd0;
                    if (s_reg + 7'd1 == ns_reg)
                    begin
                        neg_reg <= gsum_reg[63] ^ fl[63] ?
                            ((gsum_reg + fl) < 0) : (gsum_reg + fl) < 0;
                        quo_reg <= ((gsum_reg + fl) < 0) ? 64'(-(gsum_reg + fl))
                                                         : 64'(gsum_reg + fl);
                        rem_reg <= 64'd0; dcnt_reg <= 7'd0;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        s_reg <= s_reg + 7'd1;
                        state_reg <= ST_PRED;
                    end
                end
                // restoring divide, one bit per cycle
                ST_DIV:
                begin
                    if (rsh >= 64'(ns_reg))
                    begin
                        rem_reg <= rsh - 64'(ns_reg);
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rsh;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 7'd1;
                    if (dcnt_reg == 7'd63) state_reg <= ST_STEP;
                end
                // low slice of mean times rate
                ST_STEP:
                begin
                    prod_reg <= mp;
                    state_reg <= ST_STEPH;
                end
                // high slice added in, sign and shift applied
                ST_STEPH:
                begin
                    prod_reg <= stepv;
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    nw_reg[f_reg[FW-1:0]] <= sat32(64'(w_reg[f_reg[FW-1:0]]) - prod_reg);
                    gsum_reg <= 64'sd0; s_reg <= 7'd0; i_reg <= 4'd0;
                    acc_reg <= 64'sd0;
                    if (f_reg + 4'd1 == nf_reg)
                        state_reg <= ST_COPY;
                    else
                    begin
                        f_reg <= f_reg + 4'd1;
                        state_reg <= ST_PRED;
                    end
                end
                ST_COPY:
                begin
                    for (int k = 0; k < MAX_FEATURES; k++)
                        if (k < 32'(nf_reg)) w_reg[k] <= nw_reg[k];
                    it_reg <= it_reg + 16'd1;
                    state_reg <= ST_ITER;
                end
                ST_EMIT:
                begin
                    weight_valid <= 1'b1;
                    weight_index <= ecnt_reg;
                    weight <= w_reg[ecnt_reg[FW-1:0]];
                    last <= ({1'b0, ecnt_reg} + 4'd1 == nf_reg);
                    ecnt_reg <= ecnt_reg + 3'd1;
                    if ({1'b0, ecnt_reg} + 4'd1 == nf_reg) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> busy) else $error("emit while idle");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (weight_valid && last) |-> !busy) else $error("last weight but still busy");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> $past(state_reg == ST_DIV)) else $error("step without divide");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the gradient descent linear regression trainer
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import lrgd_pkg::*;

    // one emitted weight word
    typedef struct {
        logic [2:0]         idx;
        logic signed [31:0] wt;
        logic               lst;
    } weight_word_t;

    // one row of the directed table
    typedef struct {
        cmd_t               cmd;
        logic [5:0]         si;
        logic [2:0]         fi;
        logic [31:0]        val;
        bit                 typed;
        logic signed [31:0] typed_w;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] command;
    logic [5:0] sample_index;
    logic [2:0] feature_index;
    logic signed [31:0] value;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    logic weight_valid;
    logic [2:0] weight_index;
    logic signed [31:0] weight;
    logic last;

    // trainer shadow state
    logic [15:0] rate_reg;
    logic [15:0] iter_reg;
    logic [6:0] samp_reg;
    logic [3:0] feat_reg;
    logic signed [31:0] x_mem [64][8];
    logic signed [31:0] y_mem [64];
    logic signed [31:0] w_mem [8];
    bit x_seen [64][8];
    bit y_seen [64];

    weight_word_t trained_q[$];
    int mismatches;
    int burst_left;
    int sent_items;
    dir_row_t dir_rows [16];

    linear_regression_gradient_descent_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .sample_index(sample_index),
        .feature_index(feature_index), .value(value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .weight_valid(weight_valid), .weight_index(weight_index),
        .weight(weight), .last(last)
    );

    always #2 clk = ~clk;

    function automatic logic signed [31:0] clip32(input longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic int live_samples();
        if (samp_reg == 0)
            return 1;
        return (samp_reg > 64) ? 64 : int'(samp_reg);
    endfunction

    function automatic int live_features();
        if (feat_reg == 0)
            return 1;
        return (feat_reg > 8) ? 8 : int'(feat_reg);
    endfunction

    // run the descent iterations and queue the emitted weights
    task automatic descend_and_queue();
        int ns;
        int nf;
        longint acc;
        longint gsum;
        longint mean;
        longint stp;
        logic signed [31:0] err;
        logic signed [31:0] nw [8];
        weight_word_t e;
        ns = live_samples();
        nf = live_features();
        for (int it = 0; it < int'(iter_reg); it++)
        begin
            for (int f = 0; f < nf; f++)
            begin
                gsum = 0;
                for (int s = 0; s < ns; s++)
                begin
                    acc = 0;
                    for (int i = 0; i < nf; i++)
                        acc += (longint'(w_mem[i]) * longint'(x_mem[s][i])) >>> 16;
                    err = clip32(longint'(clip32(acc)) - longint'(y_mem[s]));
                    gsum += (longint'(err) * longint'(x_mem[s][f])) >>> 16;
                end
                mean = gsum / longint'(ns);
                stp = (mean * longint'({48'd0, rate_reg})) >>> 16;
                nw[f] = clip32(longint'(w_mem[f]) - stp);
            end
            for (int f = 0; f < nf; f++)
                w_mem[f] = nw[f];
        end
        for (int k = 0; k < nf; k++)
        begin
            e.idx = k[2:0];
            e.wt = w_mem[k];
            e.lst = (k + 1 == nf);
            trained_q = {trained_q, e};
        end
    endtask

    // drive one command word, with random gaps between bursts
    task automatic send_word(input cmd_t cmd, input logic [5:0] si, input logic [2:0] fi,
                             input logic [31:0] val);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 5);
        end
        burst_left--;
        start <= 1'b1;
        command <= cmd;
        sample_index <= si;
        feature_index <= fi;
        value <= val;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        sent_items++;
        // update shadow state on acceptance
        case (cmd)
            CMD_FEATURE:
            begin
                x_mem[si][fi] = val;
                x_seen[si][fi] = 1'b1;
            end
            CMD_TARGET:
            begin
                y_mem[si] = val;
                y_seen[si] = 1'b1;
            end
            CMD_WEIGHT: w_mem[fi] = val;
            default: descend_and_queue();
        endcase
    endtask

    // let the trainer drain, then settle
    task automatic settle();
        start <= 1'b0;
        burst_left = 0;
        while (trained_q.size() != 0)
            @(posedge clk);
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
        end
        @(posedge clk);
        case (idx)
            REG_RATE: rate_reg = data;
            REG_ITER: iter_reg = data;
            REG_SAMP: samp_reg = data[6:0];
            default:  feat_reg = data[3:0];
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
            2: return {{14{1'b0}}, 18'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
            default: return 32'($urandom_range(0, 32'h1ffff)) - 32'h10000;
        endcase
    endfunction

    // make sure every sample and target the next train reads is loaded
    task automatic fill_live_data();
        for (int s = 0; s < live_samples(); s++)
        begin
            for (int f = 0; f < live_features(); f++)
                if (!x_seen[s][f])
                    send_word(CMD_FEATURE, s[5:0], f[2:0], rand_value());
            if (!y_seen[s])
                send_word(CMD_TARGET, s[5:0], 3'd0, rand_value());
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        weight_word_t e;
        if (rst_n && weight_valid)
        begin
            if (trained_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected weight word: idx %0d weight %0d last %0b",
                             weight_index, weight, last);
            end
            else
            begin
                e = trained_q.pop_front();
                if (weight_index !== e.idx || weight !== e.wt || last !== e.lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("weight mismatch: exp idx %0d w %0d last %0b,",
                                 e.idx, e.wt, e.lst, " got idx %0d w %0d last %0b",
                                 weight_index, weight, last);
                end
            end
        end
    end

    // run limit
    initial
    begin
        #20000000;
        $display("FAIL linear_regression_gradient_descent_top");
        $finish;
    end

    initial
    begin
        weight_word_t e;
        int nitems;
        int pick;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_FEATURE;
        sample_index = '0;
        feature_index = '0;
        value = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_RATE;
        cfg_data = '0;
        mismatches = 0;
        burst_left = 0;
        sent_items = 0;
        rate_reg = RESET_RATE;
        iter_reg = 16'd1;
        samp_reg = 7'd1;
        feat_reg = 4'd1;
        for (int s = 0; s < 64; s++)
        begin
            y_seen[s] = 1'b0;
            y_mem[s] = '0;
            for (int f = 0; f < 8; f++)
            begin
                x_seen[s][f] = 1'b0;
                x_mem[s][f] = '0;
            end
        end
        for (int f = 0; f < 8; f++)
            w_mem[f] = '0;
        w_mem[0] = INIT_WEIGHT0;

        dir_rows = '{
            '{CMD_FEATURE, 6'd0,  3'd0, 32'h00000000, 1'b1, 32'sd0},
            '{CMD_TARGET,  6'd0,  3'd0, 32'd12345,    1'b0, 32'sd0},
            '{CMD_TRAIN,   6'd0,  3'd0, 32'h00000000, 1'b1, 32'sd150733},
            '{CMD_WEIGHT,  6'd0,  3'd0, 32'h7fffffff, 1'b0, 32'sd0},
            '{CMD_FEATURE, 6'd0,  3'd0, 32'h80000000, 1'b0, 32'sd0},
            '{CMD_TARGET,  6'd0,  3'd0, 32'h7fffffff, 1'b0, 32'sd0},
            '{CMD_TRAIN,   6'd63, 3'd7, 32'hffffffff, 1'b0, 32'sd0},
            '{CMD_FEATURE, 6'd63, 3'd7, 32'h7fffffff, 1'b0, 32'sd0},
            '{CMD_TARGET,  6'd63, 3'd7, 32'h80000000, 1'b0, 32'sd0},
            '{CMD_WEIGHT,  6'd63, 3'd7, 32'h80000000, 1'b0, 32'sd0},
            '{CMD_FEATURE, 6'd0,  3'd0, 32'h00010000, 1'b0, 32'sd0},
            '{CMD_TARGET,  6'd0,  3'd0, 32'hffff0000, 1'b0, 32'sd0},
            '{CMD_WEIGHT,  6'd0,  3'd0, 32'h00000000, 1'b0, 32'sd0},
            '{CMD_TRAIN,   6'd0,  3'd0, 32'h00000000, 1'b0, 32'sd0},
            '{CMD_FEATURE, 6'd0,  3'd0, 32'hffffffff, 1'b0, 32'sd0},
            '{CMD_TRAIN,   6'd21, 3'd2, 32'h55555555, 1'b0, 32'sd0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed rows at reset settings
        foreach (dir_rows[r])
        begin
            send_word(dir_rows[r].cmd, dir_rows[r].si, dir_rows[r].fi, dir_rows[r].val);
            // first train after reset leaves the 2.3 weight alone since x is zero
            if (dir_rows[r].typed && dir_rows[r].cmd == CMD_TRAIN)
            begin
                e = trained_q[$];
                e.wt = dir_rows[r].typed_w;
                trained_q[$] = e;
            end
        end
        settle();

        // register extremes: fast rate, out of range counts, long count written then replaced
        write_reg(REG_ITER, 16'hffff);
        write_reg(REG_RATE, 16'hffff);
        write_reg(REG_ITER, 16'd2);
        write_reg(REG_SAMP, 16'd0);
        write_reg(REG_FEAT, 16'd0);
        fill_live_data();
        send_word(CMD_TRAIN, 6'd0, 3'd0, 32'd0);
        settle();
        write_reg(REG_RATE, 16'd0);
        write_reg(REG_ITER, 16'd1);
        write_reg(REG_SAMP, 16'd2);
        write_reg(REG_FEAT, 16'hf);
        fill_live_data();
        send_word(CMD_TRAIN, 6'd0, 3'd0, 32'd0);
        settle();
        write_reg(REG_ITER, 16'd0);
        write_reg(REG_SAMP, 16'h7f);
        write_reg(REG_FEAT, 16'd8);
        send_word(CMD_TRAIN, 6'd0, 3'd0, 32'd0);
        settle();

        // random phases: new settings, loads with random content, then train
        while (sent_items < 100)
        begin
            write_reg(REG_RATE, 16'($urandom));
            write_reg(REG_ITER, 16'($urandom_range(0, 3)));
            write_reg(REG_SAMP, 16'($urandom_range(0, 8)));
            write_reg(REG_FEAT, 16'($urandom_range(0, 15)));
            nitems = $urandom_range(6, 14);
            for (int n = 0; n < nitems; n++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 7)
                    send_word(CMD_FEATURE, 6'($urandom_range(0, live_samples() - 1)),
                              3'($urandom_range(0, live_features() - 1)), rand_value());
                else if (pick < 10)
                    send_word(CMD_TARGET, 6'($urandom_range(0, live_samples() - 1)),
                              3'($urandom), rand_value());
                else if (pick < 14)
                    send_word(CMD_WEIGHT, 6'($urandom),
                              3'($urandom_range(0, live_features() - 1)), rand_value());
                else if (pick < 17)
                    send_word(cmd_t'(pick == 15 ? CMD_WEIGHT : CMD_FEATURE), 6'($urandom),
                              3'($urandom), $urandom);
                else
                begin
                    fill_live_data();
                    send_word(CMD_TRAIN, 6'($urandom), 3'($urandom), $urandom);
                end
            end
            fill_live_data();
            send_word(CMD_TRAIN, 6'($urandom), 3'($urandom), $urandom);
            settle();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && trained_q.size() == 0)
            $display("PASS linear_regression_gradient_descent_top");
        else
            $display("FAIL linear_regression_gradient_descent_top");
        $finish;
    end
endmodule
`default_nettype wire
